// File: rtl/wes_pkg.sv
// Shared types, codes and defaults for the weighted event selector.
package wes_pkg;

    localparam int DEF_WEIGHT_SLOTS = 64;
    localparam int DEF_WEIGHT_BITS  = 32;

    localparam int SLOT_W  = 6;   // slot_index field
    localparam int CNT_W   = 7;   // active_count / chosen_index
    localparam int FRAC_W  = 32;  // Q0.32 fraction
    localparam int TOTAL_W = 38;  // Q38.0 given total (unsigned integer)
    localparam int WIN_W   = 32;  // weight_value field

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam logic MODE_SUM  = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [SLOT_W-1:0]   slot_index;
        logic [WIN_W-1:0]    weight_value;
        logic [FRAC_W-1:0]   rand_fraction;
        logic [TOTAL_W-1:0]  given_total;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] chosen_index;
        logic             status;
    } out_item_t;

    // Control part of the token that walks the cell chain.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [CNT_W-1:0] idx;
    } tok_ctl_t;

endpackage

// File: rtl/wes_cell.sv
// One weight cell: holds a weight, adds it to or tests it against the passing token.
module wes_cell
    import wes_pkg::*;
#(
    parameter int CELL_ID     = 0,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int SUM_W       = 38,
    parameter int PROD_W      = 70
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [SLOT_W-1:0]      wr_slot,
    input  logic [WEIGHT_BITS-1:0] wr_data,
    input  logic                   mode,
    input  logic [CNT_W-1:0]       count,
    input  logic [PROD_W-1:0]      prod,
    input  tok_ctl_t               tok_in,
    input  logic [SUM_W-1:0]       acc_in,
    output tok_ctl_t               tok_out,
    output logic [SUM_W-1:0]       acc_out
);

    localparam bit               WRITABLE  = CELL_ID < (1 << SLOT_W);
    localparam bit               REACHABLE = CELL_ID < (1 << CNT_W);
    localparam logic [SLOT_W-1:0] SLOT_CODE = SLOT_W'(CELL_ID);
    localparam logic [CNT_W-1:0]  ID_CODE   = CNT_W'(CELL_ID);

    logic [WEIGHT_BITS-1:0] weight_reg;
    tok_ctl_t               tok_reg, tok_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;

    logic             active;
    logic [SUM_W-1:0] sum_next;
    logic             lo_ok, hi_ok;

    assign active   = REACHABLE && (count > ID_CODE);
    assign sum_next = acc_in + SUM_W'(weight_reg);
    // prefix*2^32 < r*T and r*T <= (prefix+w)*2^32
    assign lo_ok    = {acc_in, {FRAC_W{1'b0}}} < prod;
    assign hi_ok    = prod <= {sum_next, {FRAC_W{1'b0}}};

    always_comb
    begin
        tok_next = tok_in;
        acc_next = acc_in;
        if (tok_in.valid && active && !tok_in.found)
        begin
            if (mode == MODE_SUM)
            begin
                acc_next = sum_next;
            end
            else if (lo_ok && hi_ok)
            begin
                tok_next.found = 1'b1;
                tok_next.idx   = ID_CODE;
            end
            else
            begin
                acc_next = sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            if (WRITABLE && wr_en && (wr_slot == SLOT_CODE))
            begin
                weight_reg <= wr_data;
            end
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign tok_out = tok_reg;
    assign acc_out = acc_reg;

endmodule

// File: rtl/weighted_event_select.sv
// Top level of the roulette-wheel event selector: control, multiplier and cell chain.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one item per transfer.
//   A write item (opcode 0) stores weight_value into slot slot_index; a select
//   item (opcode 1) draws an event from slots 0..active_count-1, or returns active_count if none matches.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns one result per item.
//   cfg_wr_en / cfg_wr_data write active_count; write it only while idle.
// Timing:
//   One item at a time; req_stall is high from the accepting edge until the
//   result has been loaded into the output register.
//   Write: S_WRITE, then S_DONE loads the output register.  Empty list: S_DONE.
//   Select with a given total: S_MUL0..S_MUL2, then the scan pass.
//   Select with zero total: a sum pass forms the total, then S_MUL0..S_MUL2 and the scan pass.
//   Both passes are one token walking the cell chain, one cell per cycle.
//   The fraction x total product is built from two partial products: low 32 bits and upper bits of the total.
// Reset clears all weights, active_count and the handshake state.
// A stalled result stays in the output register; the next item can be taken
// meanwhile, and its result waits until the register is free.
module weighted_event_select
    import wes_pkg::*;
#(
    parameter int WEIGHT_SLOTS = DEF_WEIGHT_SLOTS,
    parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  in_item_t         req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output out_item_t        rsp_data,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data
);

    // Sum width: wide enough for the given total and for any computed sum.
    localparam int GROW_W = WEIGHT_BITS + $clog2(WEIGHT_SLOTS);
    localparam int SUM_W  = (GROW_W > TOTAL_W) ? GROW_W : TOTAL_W;
    localparam int HI_W   = SUM_W - FRAC_W;
    localparam int PROD_W = SUM_W + FRAC_W;
    localparam int N_CAP  = (WEIGHT_SLOTS < (1 << CNT_W) - 1) ?
                            WEIGHT_SLOTS : (1 << CNT_W) - 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MUL0  = 3'd3;
    localparam logic [2:0] S_MUL1  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic                    launch_reg, launch_next;
    logic [CNT_W-1:0]        active_count_reg;
    in_item_t                item_reg, item_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SUM_W-1:0]        total_reg, total_next;
    logic [2*FRAC_W-1:0]     plo_reg, plo_next;
    logic [HI_W+FRAC_W-1:0]  phi_reg, phi_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    out_item_t               res_reg, res_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    out_item_t               rsp_data_reg, rsp_data_next;

    logic [CNT_W-1:0]        n_clamp;
    logic                    mode;
    logic                    wr_en;
    logic [WEIGHT_BITS-1:0]  wr_data;

    // Token links between cells; index 0 is the chain head, WEIGHT_SLOTS the tail.
    tok_ctl_t                tok_link [WEIGHT_SLOTS+1];
    logic [SUM_W-1:0]        acc_link [WEIGHT_SLOTS+1];
    logic [WEIGHT_SLOTS-1:0] tok_valid_vec;

    // Counts above the table size fall back to the table size.
    assign n_clamp = (32'(active_count_reg) > N_CAP) ? CNT_W'(N_CAP) : active_count_reg;

    assign mode    = (state_reg == S_SCAN) ? MODE_SCAN : MODE_SUM;
    assign wr_en   = (state_reg == S_WRITE);
    assign wr_data = WEIGHT_BITS'(item_reg.weight_value);

    assign tok_link[0] = '{valid: launch_reg, found: 1'b0, idx: '0};
    assign acc_link[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < WEIGHT_SLOTS; gi++)
        begin : g_cell
            wes_cell #(
                .CELL_ID     (gi),
                .WEIGHT_BITS (WEIGHT_BITS),
                .SUM_W       (SUM_W),
                .PROD_W      (PROD_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr_en   (wr_en),
                .wr_slot (item_reg.slot_index),
                .wr_data (wr_data),
                .mode    (mode),
                .count   (cnt_reg),
                .prod    (prod_reg),
                .tok_in  (tok_link[gi]),
                .acc_in  (acc_link[gi]),
                .tok_out (tok_link[gi+1]),
                .acc_out (acc_link[gi+1])
            );
            assign tok_valid_vec[gi] = tok_link[gi+1].valid;
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req_data;
                    cnt_next  = n_clamp;
                    if (req_data.opcode == OP_WRITE)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (n_clamp == '0)
                    begin
                        res_next   = '{chosen_index: '0, status: STATUS_EMPTY};
                        state_next = S_DONE;
                    end
                    else if (req_data.given_total == '0)
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SUM;
                    end
                    else
                    begin
                        total_next = SUM_W'(req_data.given_total);
                        state_next = S_MUL0;
                    end
                end
            end
            S_WRITE:
            begin
                res_next   = '{chosen_index: '0, status: STATUS_OK};
                state_next = S_DONE;
            end
            S_SUM:
            begin
                if (tok_link[WEIGHT_SLOTS].valid)
                begin
                    total_next = acc_link[WEIGHT_SLOTS];
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                plo_next   = item_reg.rand_fraction * total_reg[FRAC_W-1:0];
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                phi_next   = item_reg.rand_fraction * total_reg[SUM_W-1:FRAC_W];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod_next   = {phi_reg, {FRAC_W{1'b0}}} + PROD_W'(plo_reg);
                launch_next = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (tok_link[WEIGHT_SLOTS].valid)
                begin
                    res_next.chosen_index = tok_link[WEIGHT_SLOTS].found ?
                                            tok_link[WEIGHT_SLOTS].idx : cnt_reg;
                    res_next.status       = STATUS_OK;
                    state_next            = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            launch_reg       <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            active_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                active_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cnt_reg      <= cnt_next;
        total_reg    <= total_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // At most one token walks the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one token in the cell chain");

    // Tokens only reach the tail during a pass.
    a_tail_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        tok_link[WEIGHT_SLOTS].valid |-> (state_reg == S_SUM || state_reg == S_SCAN))
        else $error("token left the chain outside a pass");

    // A launch only happens while in a pass.
    a_launch_state: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> (state_reg == S_SUM || state_reg == S_SCAN))
        else $error("token launched outside a pass");

    // A matched slot lies below the active count.
    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_link[WEIGHT_SLOTS].valid && tok_link[WEIGHT_SLOTS].found)
        |-> (tok_link[WEIGHT_SLOTS].idx < cnt_reg))
        else $error("matched slot outside the active range");

    // Empty-list result always reports slot zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status == STATUS_EMPTY)
        |-> (rsp_data_reg.chosen_index == '0))
        else $error("empty-list result with nonzero index");

endmodule
